// File: rtl/saes_pkg.sv
// Shared types, constants and GF(2^4) helper functions for the S-AES cipher.
package saes_pkg;

  localparam int BlockW = 16;

  localparam logic [4:0]        GfPoly  = 5'b10011;
  localparam logic [7:0]        Rcon1   = 8'h80;
  localparam logic [7:0]        Rcon2   = 8'h30;
  localparam logic [BlockW-1:0] RowKeep = 16'hF0F0;

  localparam logic [3:0] MixEncDiag = 4'h1;
  localparam logic [3:0] MixEncOff  = 4'h4;
  localparam logic [3:0] MixDecDiag = 4'h9;
  localparam logic [3:0] MixDecOff  = 4'h2;

  typedef logic [3:0] nib_t;

  typedef enum logic {
    MODE_ENC = 1'b0,
    MODE_DEC = 1'b1
  } mode_t;

  typedef struct packed {
    logic [BlockW-1:0] k1;
    logic [BlockW-1:0] k2;
    logic [BlockW-1:0] k3;
  } round_keys_t;

  typedef struct packed {
    mode_t             mode;
    logic [BlockW-1:0] data;
  } beat_t;

  localparam nib_t SboxFwd [16] = '{
    4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
  };

  localparam nib_t SboxInv [16] = '{
    4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
  };

  function automatic logic [BlockW-1:0] sub_nibbles(input logic [BlockW-1:0] v,
                                                     input logic inv);
    logic [BlockW-1:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      if (inv) begin
        r[4*i +: 4] = SboxInv[v[4*i +: 4]];
      end else begin
        r[4*i +: 4] = SboxFwd[v[4*i +: 4]];
      end
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] shift_row(input logic [BlockW-1:0] v);
    return (v & RowKeep) | {4'h0, v[3:0], 4'h0, v[11:8]};
  endfunction

  function automatic logic [7:0] rot_byte(input logic [7:0] v);
    return {v[3:0], v[7:4]};
  endfunction

  function automatic nib_t gf_mul(input nib_t a, input nib_t b);
    logic [6:0] p;
    p = '0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) begin
        p = p ^ (7'(a) << i);
      end
    end
    for (int i = 6; i >= 4; i--) begin
      if (p[i]) begin
        p = p ^ (7'(GfPoly) << (i - 4));
      end
    end
    return p[3:0];
  endfunction

  // Symmetric 2x2 matrix {{d,o},{o,d}} applied to each column.
  function automatic logic [BlockW-1:0] mix_columns(input logic [BlockW-1:0] v,
                                                     input nib_t d, input nib_t o);
    nib_t m0, m1, m2, m3;
    m0 = gf_mul(d, v[15:12]) ^ gf_mul(o, v[11:8]);
    m1 = gf_mul(o, v[15:12]) ^ gf_mul(d, v[11:8]);
    m2 = gf_mul(d, v[7:4])   ^ gf_mul(o, v[3:0]);
    m3 = gf_mul(o, v[7:4])   ^ gf_mul(d, v[3:0]);
    return {m0, m1, m2, m3};
  endfunction

  function automatic round_keys_t expand_key(input logic [BlockW-1:0] key);
    logic [7:0]  w0, w1, w2, w3, w4, w5;
    logic [15:0] t1, t3;
    round_keys_t rk;
    w0 = key[15:8];
    w1 = key[7:0];
    t1 = sub_nibbles({8'h00, rot_byte(w1)}, 1'b0);
    w2 = w0 ^ Rcon1 ^ t1[7:0];
    w3 = w2 ^ w1;
    t3 = sub_nibbles({8'h00, rot_byte(w3)}, 1'b0);
    w4 = w2 ^ Rcon2 ^ t3[7:0];
    w5 = w4 ^ w3;
    rk.k1 = {w0, w1};
    rk.k2 = {w2, w3};
    rk.k3 = {w4, w5};
    return rk;
  endfunction

endpackage

// File: rtl/simplified_aes_cipher_top.sv
// Top level of the three-stage pipelined simplified AES (16-bit) cipher.
//
// One block per clock: a beat is taken at every edge where start is high, and
// busy stays low because nothing downstream can hold results off. Each block
// leaves through the three register stages, in order, on out_block_out
// for one cycle with out_valid high. The three register stages are: first-round
// key add with nibble substitution and shift-row, mix-columns with the middle
// round key, and the last substitution with shift-row and key add; decrypt runs
// the inverse steps through the same stages. Round keys are expanded and
// registered when cfg_wr_en writes the key; write it only with the pipe empty.
module simplified_aes_cipher_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [saes_pkg::BlockW-1:0] cfg_wr_data,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic [saes_pkg::BlockW-1:0] in_block_in,
  output logic                        out_valid,
  output logic [saes_pkg::BlockW-1:0] out_block_out
);

  saes_pkg::round_keys_t       keys;
  saes_pkg::beat_t             in_beat;
  logic                        s1_valid, s2_valid, s3_valid;
  saes_pkg::beat_t             s1_beat, s2_beat, s3_beat;
  logic [saes_pkg::BlockW-1:0] s1_pre_key, s3_post_key;
  logic                        take;

  // The pipe never stalls, so every start is a beat.
  assign busy = 1'b0;
  assign take = start && !busy;

  assign in_beat.mode = saes_pkg::mode_t'(in_mode);
  assign in_beat.data = in_block_in;

  saes_key_sched u_key_sched (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .keys       (keys)
  );

  // Pick the outer round keys by direction: decrypt uses them in reverse.
  always_comb begin
    unique case (in_beat.mode)
      saes_pkg::MODE_ENC: s1_pre_key = keys.k1;
      saes_pkg::MODE_DEC: s1_pre_key = keys.k3;
      default:            s1_pre_key = keys.k1;
    endcase
    unique case (s2_beat.mode)
      saes_pkg::MODE_ENC: s3_post_key = keys.k3;
      saes_pkg::MODE_DEC: s3_post_key = keys.k1;
      default:            s3_post_key = keys.k3;
    endcase
  end

  // Stage 1: add first key, substitute and shift.
  saes_nib_stage u_stage1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (take),
    .in_beat  (in_beat),
    .pre_key  (s1_pre_key),
    .post_key ('0),
    .out_valid(s1_valid),
    .out_beat (s1_beat)
  );

  // Stage 2: mix columns around the middle key.
  saes_mix_stage u_stage2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_valid),
    .in_beat  (s1_beat),
    .mid_key  (keys.k2),
    .out_valid(s2_valid),
    .out_beat (s2_beat)
  );

  // Stage 3: substitute and shift, add last key; this is the output register.
  saes_nib_stage u_stage3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s2_valid),
    .in_beat  (s2_beat),
    .pre_key  ('0),
    .post_key (s3_post_key),
    .out_valid(s3_valid),
    .out_beat (s3_beat)
  );

  assign out_valid     = s3_valid;
  assign out_block_out = s3_beat.data;

  // Every taken beat comes out on out_valid.
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##3 out_valid)
    else $error("accepted beat did not reach the output after three cycles");

  // No result appears without a matching taken beat.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !take |-> ##3 !out_valid)
    else $error("result strobe without a matching input beat");

  // Direction travels with the block through the middle stage.
  a_mode_follow: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##2 (s2_valid && (s2_beat.mode == $past(in_beat.mode, 2))))
    else $error("block direction lost in the pipe");

  // The pipe never pushes back.
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule

// File: rtl/saes_key_sched.sv
// Key schedule: expand the written key into three registered round keys.
module saes_key_sched (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [saes_pkg::BlockW-1:0] cfg_wr_data,
  output saes_pkg::round_keys_t       keys
);

  saes_pkg::round_keys_t keys_r;
  saes_pkg::round_keys_t keys_nxt;

  always_comb begin
    keys_nxt = keys_r;
    if (cfg_wr_en) begin
      keys_nxt = saes_pkg::expand_key(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= saes_pkg::expand_key('0);
    end else begin
      keys_r <= keys_nxt;
    end
  end

  assign keys = keys_r;

endmodule

// File: rtl/saes_nib_stage.sv
// Pipeline stage: pre-key add, nibble substitution with shift-row, post-key add.
module saes_nib_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  saes_pkg::beat_t             in_beat,
  input  logic [saes_pkg::BlockW-1:0] pre_key,
  input  logic [saes_pkg::BlockW-1:0] post_key,
  output logic                        out_valid,
  output saes_pkg::beat_t             out_beat
);

  logic                        valid_r;
  saes_pkg::beat_t             beat_r;
  saes_pkg::beat_t             beat_nxt;
  logic [saes_pkg::BlockW-1:0] s;

  // Encrypt substitutes then shifts; decrypt shifts then inverse-substitutes.
  always_comb begin
    s = in_beat.data ^ pre_key;
    unique case (in_beat.mode)
      saes_pkg::MODE_ENC: s = saes_pkg::shift_row(saes_pkg::sub_nibbles(s, 1'b0));
      saes_pkg::MODE_DEC: s = saes_pkg::sub_nibbles(saes_pkg::shift_row(s), 1'b1);
      default:            s = saes_pkg::shift_row(saes_pkg::sub_nibbles(s, 1'b0));
    endcase
    beat_nxt.mode = in_beat.mode;
    beat_nxt.data = s ^ post_key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

// File: rtl/saes_mix_stage.sv
// Pipeline stage: middle-round key add and mix-columns.
module saes_mix_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  saes_pkg::beat_t             in_beat,
  input  logic [saes_pkg::BlockW-1:0] mid_key,
  output logic                        out_valid,
  output saes_pkg::beat_t             out_beat
);

  logic            valid_r;
  saes_pkg::beat_t beat_r;
  saes_pkg::beat_t beat_nxt;

  // Encrypt mixes before the key add, decrypt after it.
  always_comb begin
    beat_nxt.mode = in_beat.mode;
    unique case (in_beat.mode)
      saes_pkg::MODE_ENC: beat_nxt.data = saes_pkg::mix_columns(in_beat.data,
          saes_pkg::MixEncDiag, saes_pkg::MixEncOff) ^ mid_key;
      saes_pkg::MODE_DEC: beat_nxt.data = saes_pkg::mix_columns(in_beat.data ^ mid_key,
          saes_pkg::MixDecDiag, saes_pkg::MixDecOff);
      default:            beat_nxt.data = in_beat.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

// File: bench/saes_checker.sv
// Checker for the S-AES cipher: predicts each block from the key and compares results.
module saes_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [saes_pkg::BlockW-1:0] cfg_wr_data,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        in_mode,
  input  logic [saes_pkg::BlockW-1:0] in_block_in,
  input  logic                        out_valid,
  input  logic [saes_pkg::BlockW-1:0] out_block_out,
  output int                          fail_count,
  output int                          pending_blocks,
  output int                          blocks_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BlockW = saes_pkg::BlockW;

  localparam logic [7:0] RconFirst  = 8'h80;
  localparam logic [7:0] RconSecond = 8'h30;
  localparam logic [3:0] PolyLow    = 4'h3;  // x^4 folds back to x+1

  localparam logic [3:0] FwdBox [16] = '{
    4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
  };
  localparam logic [3:0] InvBox [16] = '{
    4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
  };

  logic [BlockW-1:0] cipher_key;
  logic [BlockW-1:0] expected_blocks [$];
  logic [BlockW-1:0] want;
  int fails = 0;
  int checked = 0;
  int pending = 0;

  assign fail_count     = fails;
  assign pending_blocks = pending;
  assign blocks_checked = checked;

  function automatic logic [BlockW-1:0] subst(input logic [BlockW-1:0] v, input logic inv);
    logic [BlockW-1:0] r;
    for (int i = 0; i < 4; i++) begin
      r[4*i +: 4] = inv ? InvBox[v[4*i +: 4]] : FwdBox[v[4*i +: 4]];
    end
    return r;
  endfunction

  // Swap nibbles 1 and 3; nibbles 0 and 2 stay.
  function automatic logic [BlockW-1:0] swap_row(input logic [BlockW-1:0] v);
    return {v[15:12], v[3:0], v[7:4], v[11:8]};
  endfunction

  function automatic logic [3:0] gf_times(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] acc;
    logic [3:0] x;
    acc = 4'h0;
    x   = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) begin
        acc ^= x;
      end
      x = {x[2:0], 1'b0} ^ (x[3] ? PolyLow : 4'h0);
    end
    return acc;
  endfunction

  function automatic logic [BlockW-1:0] mix(input logic [BlockW-1:0] v,
                                            input logic [3:0] d, input logic [3:0] o);
    return {gf_times(d, v[15:12]) ^ gf_times(o, v[11:8]),
            gf_times(o, v[15:12]) ^ gf_times(d, v[11:8]),
            gf_times(d, v[7:4])   ^ gf_times(o, v[3:0]),
            gf_times(o, v[7:4])   ^ gf_times(d, v[3:0])};
  endfunction

  function automatic logic [7:0] key_word(input logic [7:0] prev, input logic [7:0] last,
                                          input logic [7:0] rcon);
    logic [7:0] t;
    t = {FwdBox[last[3:0]], FwdBox[last[7:4]]};
    return prev ^ rcon ^ t;
  endfunction

  function automatic logic [BlockW-1:0] saes_crypt(input saes_pkg::mode_t m,
                                                   input logic [BlockW-1:0] blk,
                                                   input logic [BlockW-1:0] key);
    logic [7:0] w2, w3, w4, w5;
    logic [BlockW-1:0] rk1, rk2, rk3, s;
    w2  = key_word(key[15:8], key[7:0], RconFirst);
    w3  = w2 ^ key[7:0];
    w4  = key_word(w2, w3, RconSecond);
    w5  = w4 ^ w3;
    rk1 = key;
    rk2 = {w2, w3};
    rk3 = {w4, w5};
    if (m == saes_pkg::MODE_ENC) begin
      s = swap_row(subst(blk ^ rk1, 1'b0));
      s = mix(s, 4'h1, 4'h4) ^ rk2;
      s = swap_row(subst(s, 1'b0)) ^ rk3;
    end else begin
      s = subst(swap_row(blk ^ rk3), 1'b1) ^ rk2;
      s = mix(s, 4'h9, 4'h2);
      s = subst(swap_row(s), 1'b1) ^ rk1;
    end
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cipher_key = '0;
      expected_blocks.delete();
    end else begin
      if (out_valid) begin
        if (expected_blocks.size() == 0) begin
          $error("block_out: expected nothing, got %h", out_block_out);
          fails++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_block_out !== want) begin
            $error("block_out: expected %h, got %h", want, out_block_out);
            fails++;
          end
          checked++;
        end
      end
      if (start && !busy) begin
        expected_blocks.push_back(saes_crypt(saes_pkg::mode_t'(in_mode), in_block_in,
                                             cipher_key));
      end
      if (cfg_wr_en) begin
        cipher_key = cfg_wr_data;
      end
    end
    pending = expected_blocks.size();
  end

endmodule

// File: bench/tb_top.sv
// Top of the S-AES cipher bench: clock, reset, key writes, block stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BlockW = saes_pkg::BlockW;

  localparam int NumPhases     = 8;
  localparam int BlocksPerPhase = 200;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [BlockW-1:0] cfg_wr_data;
  logic              start;
  logic              busy;
  logic              in_mode;
  logic [BlockW-1:0] in_block_in;
  logic              out_valid;
  logic [BlockW-1:0] out_block_out;

  int fail_count;
  int pending_blocks;
  int blocks_checked;
  int blocks_sent = 0;
  int keys_written = 0;

  // Directed beats: {mode, block}. First ten run under the reset key.
  localparam logic [16:0] ResetKeyBeats [10] = '{
    {saes_pkg::MODE_ENC, 16'h0000}, {saes_pkg::MODE_DEC, 16'h0000},
    {saes_pkg::MODE_ENC, 16'hFFFF}, {saes_pkg::MODE_DEC, 16'hFFFF},
    {saes_pkg::MODE_ENC, 16'h8000}, {saes_pkg::MODE_ENC, 16'h0001},
    {saes_pkg::MODE_DEC, 16'h8000}, {saes_pkg::MODE_DEC, 16'h0001},
    {saes_pkg::MODE_ENC, 16'h0F0F}, {saes_pkg::MODE_DEC, 16'hF0F0}
  };
  // Published example: key 4AF5 turns plaintext D728 into ciphertext 24EC.
  localparam logic [16:0] KnownKeyBeats [4] = '{
    {saes_pkg::MODE_ENC, 16'hD728}, {saes_pkg::MODE_DEC, 16'h24EC},
    {saes_pkg::MODE_ENC, 16'h0000}, {saes_pkg::MODE_DEC, 16'hFFFF}
  };
  localparam logic [16:0] OnesKeyBeats [4] = '{
    {saes_pkg::MODE_ENC, 16'h5555}, {saes_pkg::MODE_DEC, 16'hAAAA},
    {saes_pkg::MODE_ENC, 16'h0000}, {saes_pkg::MODE_DEC, 16'h0000}
  };
  localparam int IdlePct [3] = '{0, 86, 35};

  simplified_aes_cipher_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_block_in  (in_block_in),
    .out_valid    (out_valid),
    .out_block_out(out_block_out)
  );

  saes_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_block_in   (in_block_in),
    .out_valid     (out_valid),
    .out_block_out (out_block_out),
    .fail_count    (fail_count),
    .pending_blocks(pending_blocks),
    .blocks_checked(blocks_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: fails a run that is still going long after the slowest legal run would end.
  initial begin
    #2_000_000;
    $display("simplified_aes_cipher_top regression: fail");
    $finish;
  end

  // Hold until every predicted block has come back out. Call at a falling edge.
  task automatic drain_pipe();
    while (pending_blocks != 0) begin
      @(negedge clk);
    end
  endtask

  // Load a new key. Only legal with the pipe empty and start low.
  task automatic load_key(input logic [BlockW-1:0] key);
    cfg_wr_data = key;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    keys_written++;
  endtask

  // Offer one beat, idling first with the given odds per cycle. Returns at the falling
  // edge after the beat was taken, leaving start high so beats can go back to back.
  task automatic send_block(input logic [16:0] beat, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start       = 1'b1;
    in_mode     = beat[16];
    in_block_in = beat[15:0];
    do begin
      @(posedge clk);
    end while (busy);
    @(negedge clk);
    blocks_sent++;
  endtask

  initial begin
    logic [BlockW-1:0] key;
    int idle;

    // Drive every input to a known value before the first edge.
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    start       = 1'b0;
    in_mode     = saes_pkg::MODE_ENC;
    in_block_in = '0;

    // Hold reset low, then release it on a falling edge.
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: extremes, both modes, zero nibbles, and the published vector,
    // all back to back so the modes interleave inside the pipe.
    foreach (ResetKeyBeats[i]) send_block(ResetKeyBeats[i], 0);
    start = 1'b0;
    drain_pipe();
    load_key(16'h4AF5);
    foreach (KnownKeyBeats[i]) send_block(KnownKeyBeats[i], 0);
    start = 1'b0;
    drain_pipe();
    load_key(16'hFFFF);
    foreach (OnesKeyBeats[i]) send_block(OnesKeyBeats[i], 0);
    start = 1'b0;
    drain_pipe();

    // Random part: each phase gets a fresh key and a sender idle rate from IdlePct.
    // The first two phases pin the key extremes; the rest draw it at random.
    for (int p = 0; p < NumPhases; p++) begin
      if (p == 0) begin
        key = 16'h0000;
      end else if (p == 1) begin
        key = 16'hFFFF;
      end else begin
        key = BlockW'($urandom);
      end
      idle = IdlePct[p % 3];
      load_key(key);
      for (int n = 0; n < BlocksPerPhase; n++) begin
        // Once, mid-phase, drop start and let the pipe run dry before resuming.
        if (p == 4 && n == BlocksPerPhase / 2) begin
          start = 1'b0;
          drain_pipe();
        end
        send_block({1'($urandom), BlockW'($urandom)}, idle);
      end
      start = 1'b0;
      drain_pipe();
    end

    // Let the three-stage pipe settle a little past the last block, then judge.
    repeat (10) @(negedge clk);
    if (pending_blocks != 0) begin
      $error("block_out: %0d expected blocks never came out", pending_blocks);
    end

    $display("Covered %0d blocks (%0d checked) in both modes under %0d key loads,",
             blocks_sent, blocks_checked, keys_written);
    $display("with sender idle rates of 0, 35 and 86 percent, draining before each key load.");
    if (fail_count == 0 && pending_blocks == 0) begin
      $display("simplified_aes_cipher_top regression: pass");
    end else begin
      $display("simplified_aes_cipher_top regression: fail");
    end
    $finish;
  end

endmodule
